// File: src/relation_symmetry_checker_top_macros.svh
// Assertion helpers for the relation symmetry checker.
// RSC_ASSERT_NOW checks the consequent in the same cycle as the antecedent.
// RSC_ASSERT_NEXT checks it in the cycle after the antecedent.
`ifndef RELATION_SYMMETRY_CHECKER_TOP_MACROS_SVH
`define RELATION_SYMMETRY_CHECKER_TOP_MACROS_SVH
`ifndef SYNTH
`define RSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("relation symmetry checker assertion failed");
`define RSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("relation symmetry checker assertion failed");
`else
`define RSC_ASSERT_NOW(lbl, ante, cons)
`define RSC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/rsc_pkg.sv
package rsc_pkg;

  localparam int unsigned MAX_PENDING = 256;
  localparam int unsigned VALUE_BITS  = 16;
  localparam int unsigned PAIR_BITS   = 2 * VALUE_BITS;
  localparam int unsigned CNT_BITS    = $clog2(MAX_PENDING + 1);

  typedef logic [PAIR_BITS-1:0] pair_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef enum logic [1:0] {
    VERDICT_SYM  = 2'd0,
    VERDICT_ASYM = 2'd1,
    VERDICT_OVF  = 2'd2
  } verdict_e;

  // Search token that walks the cell chain.
  typedef struct packed {
    logic  vld;
    logic  matched;  // a stored mirror was removed upstream
    logic  placed;   // a cell holds this pair tentatively
    pair_t mirror;   // (b,a)
    pair_t self;     // (a,b)
  } tok_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic commit;
    logic cancel;
    logic clear;
  } cmd_t;

endpackage

// File: src/rsc_cell.sv
module rsc_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rsc_pkg::tok_t tok_i,
  input  rsc_pkg::cmd_t cmd_i,
  output rsc_pkg::tok_t tok_o
);
  import rsc_pkg::*;

  logic  valid_q, valid_d;
  logic  tent_q, tent_d;
  pair_t pair_q;
  tok_t  tok_q, tok_d;
  logic  hit, take;

  // Remove a stored mirror, or claim this empty slot for the pair.
  assign hit  = tok_i.vld && !tok_i.matched && valid_q && !tent_q &&
                (pair_q == tok_i.mirror);
  assign take = tok_i.vld && !tok_i.matched && !tok_i.placed && !valid_q;

  always_comb begin
    valid_d = valid_q;
    tent_d  = tent_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
      tent_d  = 1'b0;
    end else if (tent_q && cmd_i.commit) begin
      tent_d = 1'b0;
    end else if (tent_q && cmd_i.cancel) begin
      valid_d = 1'b0;
      tent_d  = 1'b0;
    end else if (hit) begin
      valid_d = 1'b0;
    end else if (take) begin
      valid_d = 1'b1;
      tent_d  = 1'b1;
    end
  end

  always_comb begin
    tok_d         = tok_i;
    tok_d.matched = tok_i.matched | hit;
    tok_d.placed  = tok_i.placed | take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tent_q  <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tent_q  <= tent_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !cmd_i.clear) begin
      pair_q <= tok_i.self;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: src/rsc_ctrl.sv
`include "relation_symmetry_checker_top_macros.svh"

module rsc_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [rsc_pkg::VALUE_BITS-1:0]  first_value_i,
  input  logic [rsc_pkg::VALUE_BITS-1:0]  second_value_i,
  input  logic                            last_pair_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      verdict_o,
  output rsc_pkg::tok_t                   tok_o,
  input  rsc_pkg::tok_t                   tail_i,
  output rsc_pkg::cmd_t                   cmd_o
);
  import rsc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_e;

  state_e   state_q;
  logic     last_q;
  cnt_t     count_q;
  logic     ovf_q;
  tok_t     inj_q, inj_d;
  cmd_t     cmd_q, cmd_d;
  logic     out_vld_q;
  verdict_e verdict_q;
  logic     issue;

  assign in_stall_o = (state_q != ST_IDLE);

  // Send the verdict once the output register is empty or drains this cycle.
  assign issue = (state_q == ST_FIN) && last_q && (!out_vld_q || !out_stall_i);

  always_comb begin
    inj_d = '0;
    if ((state_q == ST_IDLE) && in_valid_i && (first_value_i != second_value_i)) begin
      inj_d.vld    = 1'b1;
      inj_d.self   = {first_value_i, second_value_i};
      inj_d.mirror = {second_value_i, first_value_i};
    end
    cmd_d = '0;
    if ((state_q == ST_WALK) && tail_i.vld) begin
      cmd_d.cancel = tail_i.matched;
      cmd_d.commit = !tail_i.matched && tail_i.placed;
    end
    cmd_d.clear = issue;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      last_q    <= 1'b0;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      inj_q     <= '0;
      cmd_q     <= '0;
      out_vld_q <= 1'b0;
      verdict_q <= VERDICT_SYM;
    end else begin
      inj_q     <= inj_d;
      cmd_q     <= cmd_d;
      out_vld_q <= issue || (out_vld_q && out_stall_i);
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            last_q <= last_pair_i;
            if (first_value_i != second_value_i) begin
              state_q <= ST_WALK;
            end else if (last_pair_i) begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_WALK: begin
          if (tail_i.vld) begin
            if (tail_i.matched) begin
              count_q <= count_q - cnt_t'(1);
            end else if (tail_i.placed) begin
              count_q <= count_q + cnt_t'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!last_q) begin
            state_q <= ST_IDLE;
          end else if (issue) begin
            if (ovf_q) begin
              verdict_q <= VERDICT_OVF;
            end else if (count_q == '0) begin
              verdict_q <= VERDICT_SYM;
            end else begin
              verdict_q <= VERDICT_ASYM;
            end
            count_q <= '0;
            ovf_q   <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign tok_o       = inj_q;
  assign cmd_o       = cmd_q;
  assign out_valid_o = out_vld_q;
  assign verdict_o   = verdict_q;

  `RSC_ASSERT_NOW(a_tail_in_walk, tail_i.vld, state_q == ST_WALK)
  `RSC_ASSERT_NOW(a_clear_zeroed, cmd_q.clear, (count_q == '0) && !ovf_q)
  `RSC_ASSERT_NEXT(a_drop_sets_ovf, tail_i.vld && !tail_i.matched && !tail_i.placed, ovf_q)
  `RSC_ASSERT_NOW(a_place_has_room, cmd_d.commit, count_q != cnt_t'(MAX_PENDING))

endmodule

// File: src/relation_symmetry_checker_top.sv
// Relation symmetry checker.
// Input channel: one beat per pair (first_value_i, second_value_i) with
// last_pair_i high on the final pair of a relation; accepted when in_valid_i
// is high and in_stall_o is low. Output channel: one beat per relation,
// verdict_o = 0 symmetric, 1 not symmetric, 2 pending table overflowed;
// taken when out_valid_o is high and out_stall_i is low.
// Each pair that is not of the form (a,a) sends a search token down a chain
// of MAX_PENDING cells, one cell per cycle. A cell holding the mirror pair
// drops it; otherwise the first empty cell holds the pair tentatively and the
// controller commits or cancels it once the token leaves the chain.
// A new pair waits behind in_stall_o until the token of the previous one has
// left the chain and been settled; a reflexive pair walks no chain.
// out_valid_o rises once the last pair is settled and the verdict register
// has been loaded, which waits for the output register to be free.
// Reset empties every cell, the count and the overflow flag; the block is
// ready for a pair in the first cycle after reset. A verdict beat also clears
// the table for the next relation. When the receiver stalls, the verdict
// holds in the output register; earlier pairs still go through, and only a
// following last pair waits for the register to free up.
module relation_symmetry_checker_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [rsc_pkg::VALUE_BITS-1:0]  first_value_i,
  input  logic [rsc_pkg::VALUE_BITS-1:0]  second_value_i,
  input  logic                            last_pair_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      verdict_o
);
  import rsc_pkg::*;

  // Token path: link 0 is fed by the controller, the last link returns to it.
  tok_t tok_link [MAX_PENDING+1];
  cmd_t cmd;

  rsc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .last_pair_i    (last_pair_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .verdict_o      (verdict_o),
    .tok_o          (tok_link[0]),
    .tail_i         (tok_link[MAX_PENDING]),
    .cmd_o          (cmd)
  );

  // Chain of pending-pair cells; the commit, cancel and clear broadcast
  // reaches all of them in the same cycle.
  for (genvar i = 0; i < MAX_PENDING; i++) begin : g_cell
    rsc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok_link[i]),
      .cmd_i  (cmd),
      .tok_o  (tok_link[i+1])
    );
  end

endmodule
